### hw/rtl/frd_pkg.sv
// Package for the fraction reducer: widths, payload structs, controller state
// and the command and status structs between controller and datapath.
// No dependencies.
package frd_pkg;

   localparam int FRD_WIDTH = 32;
   localparam int FRD_CNT_W = $clog2(FRD_WIDTH);

   typedef struct packed {
      logic signed [FRD_WIDTH-1:0] numerator;
      logic signed [FRD_WIDTH-1:0] denominator;
   } req_type;

   typedef struct packed {
      logic signed [FRD_WIDTH-1:0] reduced_numerator;
      logic signed [FRD_WIDTH-1:0] reduced_denominator;
      logic                        invalid;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_EUC,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_FINISH
   } state_type;

   // Operand selection for the shared divider.
   typedef enum logic [1:0] {
      SEL_INIT,
      SEL_EUC_NEXT,
      SEL_NUM,
      SEL_DEN
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        start_div;
      div_sel_type sel;
      logic        bypass;
      logic        latch_num;
      logic        latch_den;
      logic        write_out;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic d_zero;
      logic div_done;
      logic rem_zero;
      logic out_free;
   } status_type;

   // Applies a sign to a magnitude, wrapping to the field width.
   function automatic logic [FRD_WIDTH-1:0] from_smag(input logic neg,
                                                     input logic [FRD_WIDTH-1:0] mag);
      from_smag = neg ? (~mag + 1'b1) : mag;
   endfunction

endpackage

### hw/rtl/frd_divider.sv
// Bit-serial restoring divider on unsigned magnitudes, one quotient bit a cycle.
// Depends on frd_pkg.
module frd_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [frd_pkg::FRD_WIDTH-1:0]  dividend,
   input  logic [frd_pkg::FRD_WIDTH-1:0]  divisor,
   output logic [frd_pkg::FRD_WIDTH-1:0]  quotient,
   output logic [frd_pkg::FRD_WIDTH-1:0]  remainder,
   output logic                           done
);
   import frd_pkg::*;

   localparam logic [FRD_CNT_W-1:0] LAST_STEP = FRD_CNT_W'(FRD_WIDTH - 1);

   logic [FRD_WIDTH-1:0] rem_ff, rem_in;
   logic [FRD_WIDTH-1:0] quo_ff, quo_in;
   logic [FRD_WIDTH-1:0] dvsr_ff, dvsr_in;
   logic [FRD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [FRD_WIDTH:0]   trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[FRD_WIDTH-1]} - {1'b0, dvsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvsr_in = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // A negative trial keeps the shifted partial remainder.
         if (trial[FRD_WIDTH]) begin
            rem_in = {rem_ff[FRD_WIDTH-2:0], quo_ff[FRD_WIDTH-1]};
            quo_in = {quo_ff[FRD_WIDTH-2:0], 1'b0};
         end else begin
            rem_in = trial[FRD_WIDTH-1:0];
            quo_in = {quo_ff[FRD_WIDTH-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_busy_ends: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start) |=> (busy_ff || done_ff)) else $error("divider stopped early");

endmodule

### hw/rtl/frd_datapath.sv
// Datapath: operand registers, Euclid sign tracking, result and output registers.
// Depends on frd_pkg and frd_divider.
module frd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  frd_pkg::cmd_type    cmd,
   output frd_pkg::status_type status,
   input  frd_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output frd_pkg::rsp_type    rsp_data
);
   import frd_pkg::*;

   logic [FRD_WIDTH-1:0] n_raw_ff, d_raw_ff;
   logic [FRD_WIDTH-1:0] n_mag_ff, d_mag_ff, b_mag_ff;
   logic                 n_neg_ff, d_neg_ff, a_neg_ff, b_neg_ff;
   logic [FRD_WIDTH-1:0] res_num_ff, res_den_ff;
   logic                 res_inv_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic [FRD_WIDTH-1:0] dividend, divisor, quotient, remainder;
   logic                 div_done;
   logic [FRD_WIDTH-1:0] n_in, d_in;

   assign n_in = req_data.numerator;
   assign d_in = req_data.denominator;

   always_comb begin
      case (cmd.sel)
         SEL_INIT: begin
            dividend = n_mag_ff;
            divisor  = d_mag_ff;
         end
         SEL_EUC_NEXT: begin
            dividend = b_mag_ff;
            divisor  = remainder;
         end
         SEL_NUM: begin
            dividend = n_mag_ff;
            divisor  = b_mag_ff;
         end
         SEL_DEN: begin
            dividend = d_mag_ff;
            divisor  = b_mag_ff;
         end
         default: begin
            dividend = n_mag_ff;
            divisor  = d_mag_ff;
         end
      endcase
   end

   frd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_div),
      .dividend  (dividend),
      .divisor   (divisor),
      .quotient  (quotient),
      .remainder (remainder),
      .done      (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_raw_ff <= n_in;
         d_raw_ff <= d_in;
         n_neg_ff <= n_in[FRD_WIDTH-1];
         d_neg_ff <= d_in[FRD_WIDTH-1];
         // The most negative value negates to itself, which is its magnitude.
         n_mag_ff <= n_in[FRD_WIDTH-1] ? (~n_in + 1'b1) : n_in;
         d_mag_ff <= d_in[FRD_WIDTH-1] ? (~d_in + 1'b1) : d_in;
      end
      if (cmd.start_div && cmd.sel == SEL_INIT) begin
         a_neg_ff <= n_neg_ff;
         b_neg_ff <= d_neg_ff;
         b_mag_ff <= d_mag_ff;
      end else if (cmd.start_div && cmd.sel == SEL_EUC_NEXT) begin
         // A nonzero truncating remainder carries the dividend's sign.
         a_neg_ff <= b_neg_ff;
         b_neg_ff <= a_neg_ff;
         b_mag_ff <= remainder;
      end
      if (cmd.bypass) begin
         res_num_ff <= n_raw_ff;
         res_den_ff <= d_raw_ff;
         res_inv_ff <= (d_raw_ff == '0);
      end
      if (cmd.latch_num) begin
         res_num_ff <= from_smag(n_neg_ff ^ b_neg_ff, quotient);
         res_inv_ff <= 1'b0;
      end
      if (cmd.latch_den) begin
         res_den_ff <= from_smag(d_neg_ff ^ b_neg_ff, quotient);
      end
      if (cmd.write_out) begin
         rsp_data_ff.reduced_numerator   <= res_num_ff;
         rsp_data_ff.reduced_denominator <= res_den_ff;
         rsp_data_ff.invalid             <= res_inv_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.n_zero   = (n_raw_ff == '0);
      status.d_zero   = (d_raw_ff == '0);
      status.div_done = div_done;
      status.rem_zero = (remainder == '0);
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      cmd.write_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten");

endmodule

### hw/rtl/frd_ctrl.sv
// Controller state machine: sequences load, Euclid remainders and final divisions.
// Depends on frd_pkg.
module frd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  frd_pkg::status_type status,
   output frd_pkg::cmd_type    cmd
);
   import frd_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.d_zero || status.n_zero) state_in = ST_FINISH;
            else state_in = ST_DIV_EUC;
         end
         ST_DIV_EUC: begin
            if (status.div_done && status.rem_zero) state_in = ST_DIV_NUM;
         end
         ST_DIV_NUM: begin
            if (status.div_done) state_in = ST_DIV_DEN;
         end
         ST_DIV_DEN: begin
            if (status.div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.sel   = SEL_INIT;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_CHECK: begin
            if (status.d_zero || status.n_zero) begin
               cmd.bypass = 1'b1;
            end else begin
               cmd.start_div = 1'b1;
               cmd.sel       = SEL_INIT;
            end
         end
         ST_DIV_EUC: begin
            if (status.div_done) begin
               cmd.start_div = 1'b1;
               // A zero remainder leaves the divisor in the b register.
               cmd.sel       = status.rem_zero ? SEL_NUM : SEL_EUC_NEXT;
            end
         end
         ST_DIV_NUM: begin
            if (status.div_done) begin
               cmd.latch_num = 1'b1;
               cmd.start_div = 1'b1;
               cmd.sel       = SEL_DEN;
            end
         end
         ST_DIV_DEN: begin
            cmd.latch_den = status.div_done;
         end
         ST_FINISH: begin
            cmd.write_out = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      status.div_done |->
         (state_ff == ST_DIV_EUC || state_ff == ST_DIV_NUM || state_ff == ST_DIV_DEN))
      else $error("divider finished outside a division state");

endmodule

### hw/rtl/fraction_reducer_core.sv
// Top level of the fraction reducer: controller plus datapath.
// Depends on frd_pkg, frd_ctrl and frd_datapath.
//
//   channel  direction  ports                           payload
//   req      in         req_valid, req_stall, req_data  numerator, denominator
//   rsp      out        rsp_valid, rsp_stall, rsp_data  reduced pair, invalid
//
// A transaction with a zero numerator or denominator bypasses the divider.
// Otherwise it runs the Euclid remainders and then the numerator and denominator
// divisions on the bit-serial divider, which is shared by all divisions.
// One transaction is in work at a time; the next is taken while a result waits.
// Synchronous reset clears the controller and the output valid.
// A stalled result holds in the output register and blocks only the next write.
module fraction_reducer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  frd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output frd_pkg::rsp_type rsp_data
);
   import frd_pkg::*;

   cmd_type    cmd;
   status_type status;

   frd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   frd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
